// ===== sv/slex_pkg.sv =====
// ----------------------------------------------------------------------------
// slex_pkg: shared types and constants for the small language lexer
// Token kinds, scan modes, status codes, keyword table and character classes.
// ----------------------------------------------------------------------------
package slex_pkg;

  localparam int MAX_TOKEN_CHARS_DEF = 8;
  localparam int LINE_BITS_DEF       = 16;
  localparam int TEXT_W              = 64;
  localparam int LEN_W               = 4;
  localparam int LINE_W              = 16;
  localparam int NUM_KW              = 11;
  localparam int FIFO_DEPTH          = 4;

  typedef enum logic [5:0] {
    K_INT, K_BOOL, K_IF, K_THEN, K_ELSE, K_WHILE, K_DO, K_READ, K_WRITE,
    K_TRUE, K_FALSE, K_IDENT, K_NUMBER,
    K_PLUS, K_MINUS, K_STAR, K_SLASH, K_GT, K_GE, K_LT, K_LE, K_EQ, K_NE,
    K_OR, K_AND, K_NOT, K_ASSIGN, K_BECOMES, K_LBRACE, K_RBRACE,
    K_LPAREN, K_RPAREN, K_SEMI, K_COMMA, K_ILLEGAL, K_REPORT
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK, ST_LONG, ST_ILLEGAL, ST_OPEN_COMMENT
  } status_t;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_WORD, MODE_NUM, MODE_HELD, MODE_LCOM, MODE_BCOM, MODE_BSTAR
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [TEXT_W-1:0]  text;
    logic [LEN_W-1:0]   len;
    logic [LINE_W-1:0]  line;
    status_t            status;
    logic               last;
  } tok_t;

  // keyword text, first character in the low byte
  localparam logic [TEXT_W-1:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0074_6E69,  // int
    64'h0000_0000_6C6F_6F62,  // bool
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6E65_6874,  // then
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0065_6C69_6877,  // while
    64'h0000_0000_0000_6F64,  // do
    64'h0000_0000_6461_6572,  // read
    64'h0000_0065_7469_7277,  // write
    64'h0000_0000_6575_7274,  // true
    64'h0000_0065_736C_6166   // false
  };

  localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd4, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd5, 4'd4, 4'd5
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {" ", [8'd9:8'd13]};
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return c inside {">", "<", "=", "!", "|", "&", ":", "/"};
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {["A":"Z"]}) ? 8'(c + 8'd32) : c;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      ">":     k = K_GT;
      "<":     k = K_LT;
      "!":     k = K_NOT;
      "=":     k = K_ASSIGN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      ";":     k = K_SEMI;
      ",":     k = K_COMMA;
      default: k = K_ILLEGAL;
    endcase
    return k;
  endfunction

  // K_ILLEGAL means the pair is not an operator
  function automatic kind_t pair_kind(input logic [7:0] h, input logic [7:0] c);
    kind_t k;
    k = K_ILLEGAL;
    if (h == ">" && c == "=") k = K_GE;
    if (h == "<" && c == "=") k = K_LE;
    if (h == "=" && c == "=") k = K_EQ;
    if (h == "!" && c == "=") k = K_NE;
    if (h == "|" && c == "|") k = K_OR;
    if (h == "&" && c == "&") k = K_AND;
    if (h == ":" && c == "=") k = K_BECOMES;
    return k;
  endfunction

  function automatic tok_t single_tok(input logic [7:0] c, input logic [LINE_W-1:0] line);
    tok_t t;
    t.kind   = single_kind(c);
    t.text   = TEXT_W'(c);
    t.len    = LEN_W'(1);
    t.line   = line;
    t.status = (t.kind == K_ILLEGAL) ? ST_ILLEGAL : ST_OK;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

// ===== sv/slex_ifs.sv =====
// ----------------------------------------------------------------------------
// slex_ifs: source byte and token channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface slex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, ch, end_of_text, input ready);
  modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface slex_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [63:0] token_text;
  logic [3:0]  text_length;
  logic [15:0] line;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, token_kind, token_text, text_length, line, status, last,
                  input ready);
  modport sink   (input valid, token_kind, token_text, text_length, line, status, last,
                  output ready);
endinterface

// ===== sv/small_language_lexer.sv =====
// ----------------------------------------------------------------------------
// small_language_lexer: streaming lexer, one source byte per cycle while in_bus.ready is high
// Scan state registers feed token logic that writes a four-entry result queue.
// A token is written to the queue as the byte that ends it is taken; out_bus shows the queue head.
// Throughput: one byte per cycle while in_bus.ready is high; a byte that ends two tokens
// pushes both into the queue together. in_bus.ready drops when fewer than two queue
// slots are free. Synchronous active-low reset: idle mode, line 1, queue empty.
// ----------------------------------------------------------------------------
module small_language_lexer #(
  parameter int MAX_TOKEN_CHARS = slex_pkg::MAX_TOKEN_CHARS_DEF,
  parameter int LINE_BITS       = slex_pkg::LINE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  slex_in_if.sink           in_bus,
  slex_out_if.source        out_bus
);

  localparam int PTR_W = $clog2(slex_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(slex_pkg::FIFO_DEPTH + 1);
  localparam logic [slex_pkg::LEN_W-1:0] MAX_LEN  = slex_pkg::LEN_W'(MAX_TOKEN_CHARS);
  localparam logic [slex_pkg::LEN_W-1:0] LONG_LEN = slex_pkg::LEN_W'(MAX_TOKEN_CHARS + 1);

  slex_pkg::mode_t                   mode_r, mode_nxt;
  logic [7:0]                        held_r, held_nxt;
  logic [slex_pkg::TEXT_W-1:0]       buf_r, buf_nxt, app_buf;
  logic [slex_pkg::LEN_W-1:0]        cnt_r, cnt_nxt, app_cnt;
  logic [LINE_BITS-1:0]              tline_r, tline_nxt;
  logic [LINE_BITS-1:0]              cline_r, cline_nxt, cline_inc;
  logic [LINE_BITS-1:0]              mline_r, mline_nxt;

  slex_pkg::tok_t                    fifo_r [slex_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]                  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]                  count_r;

  logic [7:0]                        c, lc;
  logic                              in_fire, out_fire, eot;
  logic                              pend_v, fresh_v, do_fresh;
  slex_pkg::tok_t                    pend, fresh, slot0, slot1;
  logic [1:0]                        n_push;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;
  assign c        = in_bus.ch;
  assign eot      = in_bus.end_of_text;
  assign lc       = slex_pkg::to_lower(c);
  assign cline_inc = (cline_r != '1) ? LINE_BITS'(cline_r + 1'b1) : cline_r;

  function automatic slex_pkg::tok_t pending_tok(input logic word);
    slex_pkg::tok_t t;
    logic           hit;
    hit      = 1'b0;
    t.kind   = word ? slex_pkg::K_IDENT : slex_pkg::K_NUMBER;
    t.text   = buf_r;
    t.len    = cnt_r;
    t.line   = slex_pkg::LINE_W'(tline_r);
    t.status = (cnt_r > MAX_LEN) ? slex_pkg::ST_LONG : slex_pkg::ST_OK;
    t.last   = 1'b0;
    if (word && t.status == slex_pkg::ST_OK) begin
      for (int i = 0; i < slex_pkg::NUM_KW; i++) begin
        if (!hit && slex_pkg::KW_LEN[i] == cnt_r && slex_pkg::KW_TEXT[i] == buf_r) begin
          hit    = 1'b1;
          t.kind = slex_pkg::kind_t'(6'(i));
        end
      end
    end
    return t;
  endfunction

  // append one lowercased character to the token buffer, or mark the token too long when full
  always_comb begin
    app_buf = buf_r;
    app_cnt = LONG_LEN;
    if (cnt_r < MAX_LEN) begin
      app_buf[{cnt_r[2:0], 3'b000} +: 8] = lc;
      app_cnt = slex_pkg::LEN_W'(cnt_r + 1'b1);
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    tline_nxt = tline_r;
    cline_nxt = cline_r;
    mline_nxt = mline_r;
    pend_v    = 1'b0;
    pend      = '0;
    fresh_v   = 1'b0;
    fresh     = '0;
    do_fresh  = 1'b0;
    if (in_fire) begin
      if (eot) begin
        case (mode_r)
          slex_pkg::MODE_WORD: begin
            pend_v = 1'b1;
            pend   = pending_tok(1'b1);
          end
          slex_pkg::MODE_NUM: begin
            pend_v = 1'b1;
            pend   = pending_tok(1'b0);
          end
          slex_pkg::MODE_HELD: begin
            pend_v = 1'b1;
            pend   = slex_pkg::single_tok(held_r, slex_pkg::LINE_W'(tline_r));
          end
          slex_pkg::MODE_BCOM, slex_pkg::MODE_BSTAR: begin
            pend_v      = 1'b1;
            pend.kind   = slex_pkg::K_REPORT;
            pend.line   = slex_pkg::LINE_W'(mline_r);
            pend.status = slex_pkg::ST_OPEN_COMMENT;
          end
          default: ;
        endcase
        mode_nxt  = slex_pkg::MODE_IDLE;
        held_nxt  = '0;
        buf_nxt   = '0;
        cnt_nxt   = '0;
        tline_nxt = LINE_BITS'(1);
        cline_nxt = LINE_BITS'(1);
        mline_nxt = LINE_BITS'(1);
      end else begin
        case (mode_r)
          slex_pkg::MODE_LCOM: begin
            if (c == "\n") begin
              mode_nxt  = slex_pkg::MODE_IDLE;
              cline_nxt = cline_inc;
            end
          end
          slex_pkg::MODE_BCOM, slex_pkg::MODE_BSTAR: begin
            if (mode_r == slex_pkg::MODE_BSTAR && c == "/") begin
              mode_nxt = slex_pkg::MODE_IDLE;
            end else begin
              mode_nxt = (c == "*") ? slex_pkg::MODE_BSTAR : slex_pkg::MODE_BCOM;
            end
            if (c == "\n") cline_nxt = cline_inc;
          end
          slex_pkg::MODE_WORD: begin
            if (slex_pkg::is_alpha(c) || slex_pkg::is_digit(c) || c == "_") begin
              buf_nxt = app_buf;
              cnt_nxt = app_cnt;
            end else begin
              pend_v   = 1'b1;
              pend     = pending_tok(1'b1);
              do_fresh = 1'b1;
            end
          end
          slex_pkg::MODE_NUM: begin
            if (slex_pkg::is_digit(c)) begin
              buf_nxt = app_buf;
              cnt_nxt = app_cnt;
            end else begin
              pend_v   = 1'b1;
              pend     = pending_tok(1'b0);
              do_fresh = 1'b1;
            end
          end
          slex_pkg::MODE_HELD: begin
            if (held_r == "/" && c == "/") begin
              mode_nxt = slex_pkg::MODE_LCOM;
            end else if (held_r == "/" && c == "*") begin
              mline_nxt = tline_r;
              mode_nxt  = slex_pkg::MODE_BCOM;
            end else if (slex_pkg::pair_kind(held_r, c) != slex_pkg::K_ILLEGAL) begin
              pend_v      = 1'b1;
              pend.kind   = slex_pkg::pair_kind(held_r, c);
              pend.text   = slex_pkg::TEXT_W'({c, held_r});
              pend.len    = slex_pkg::LEN_W'(2);
              pend.line   = slex_pkg::LINE_W'(tline_r);
              pend.status = slex_pkg::ST_OK;
              mode_nxt    = slex_pkg::MODE_IDLE;
            end else begin
              pend_v   = 1'b1;
              pend     = slex_pkg::single_tok(held_r, slex_pkg::LINE_W'(tline_r));
              do_fresh = 1'b1;
            end
          end
          default: do_fresh = 1'b1;
        endcase

        if (do_fresh) begin
          mode_nxt = slex_pkg::MODE_IDLE;
          if (slex_pkg::is_space(c)) begin
            if (c == "\n") cline_nxt = cline_inc;
          end else if (slex_pkg::is_alpha(c) || slex_pkg::is_digit(c) || c == "_") begin
            mode_nxt  = slex_pkg::is_digit(c) ? slex_pkg::MODE_NUM : slex_pkg::MODE_WORD;
            buf_nxt   = slex_pkg::TEXT_W'(lc);
            cnt_nxt   = slex_pkg::LEN_W'(1);
            tline_nxt = cline_r;
          end else if (slex_pkg::is_op_start(c)) begin
            mode_nxt  = slex_pkg::MODE_HELD;
            held_nxt  = c;
            tline_nxt = cline_r;
          end else begin
            fresh_v = 1'b1;
            fresh   = slex_pkg::single_tok(c, slex_pkg::LINE_W'(cline_r));
          end
        end
      end
    end
  end

  // pack results into queue slots, flag the final one
  always_comb begin
    slot0 = pend_v ? pend : fresh;
    slot1 = fresh;
    n_push = 2'(pend_v) + 2'(fresh_v);
    slot0.last = (n_push == 2'd1);
    slot1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= slex_pkg::MODE_IDLE;
      held_r  <= '0;
      buf_r   <= '0;
      cnt_r   <= '0;
      tline_r <= LINE_BITS'(1);
      cline_r <= LINE_BITS'(1);
      mline_r <= LINE_BITS'(1);
    end else begin
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      tline_r <= tline_nxt;
      cline_r <= cline_nxt;
      mline_r <= mline_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) fifo_r[wr_ptr_r] <= slot0;
    if (n_push == 2'd2) fifo_r[PTR_W'(wr_ptr_r + 1'b1)] <= slot1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= PTR_W'(wr_ptr_r + n_push);
      if (out_fire) rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      count_r  <= CNT_W'(count_r + n_push - CNT_W'(out_fire));
    end
  end

  assign in_bus.ready        = (count_r <= CNT_W'(slex_pkg::FIFO_DEPTH - 2));
  assign out_bus.valid       = (count_r != '0);
  assign out_bus.token_kind  = fifo_r[rd_ptr_r].kind;
  assign out_bus.token_text  = fifo_r[rd_ptr_r].text;
  assign out_bus.text_length = fifo_r[rd_ptr_r].len;
  assign out_bus.line        = fifo_r[rd_ptr_r].line;
  assign out_bus.status      = fifo_r[rd_ptr_r].status;
  assign out_bus.last        = fifo_r[rd_ptr_r].last;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(slex_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && eot |=> mode_r == slex_pkg::MODE_IDLE && cline_r == LINE_BITS'(1))
    else $error("end of text did not reset scan state");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !in_fire |=> count_r == CNT_W'($past(count_r) - 1'b1))
    else $error("queue count mismatch on transfer out");

  a_held_op: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == slex_pkg::MODE_HELD |-> slex_pkg::is_op_start(held_r))
    else $error("held character is not an operator start");

endmodule
